>>> hw/rtl/bpa_pkg.sv
// Package for the buddy page allocator: command, status and operation codes,
// the controller/datapath interface structs and a lowest-set-bit helper.
// No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_ADD   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_BADORDER = 2'd2;
    localparam logic [1:0] ST_MISALIGN = 2'd3;

    typedef logic [2:0] dp_op_t;

    localparam dp_op_t OP_NONE  = 3'd0;
    localparam dp_op_t OP_LOAD  = 3'd1;
    localparam dp_op_t OP_CHECK = 3'd2;
    localparam dp_op_t OP_PICK  = 3'd3;
    localparam dp_op_t OP_SPLIT = 3'd4;
    localparam dp_op_t OP_EVAL  = 3'd5;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_nop;
        logic bad_order;
        logic misalign;
        logic found;
        logic at_target;
        logic eval_merge;
        logic out_free;
    } dp_status_t;

    function automatic logic [5:0] lowest64(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd63;
        for (int i = 62; i >= 0; i--) begin
            if (v[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/buddy_page_allocator.sv
// Buddy page allocator: 1 KiB pages in 64 KiB segments, one result per item.
// A command is loaded and checked; an allocate then picks a free block and splits
// it down to the asked order, a free merges it with free buddies upward and an add
// just marks it free. One item is in flight at a time, and the next item can be
// taken in the cycle after the result is loaded.
// Reset clears all free bitmaps at once through per-entry valid bits.
`timescale 1ns / 1ps

module buddy_page_allocator #(
    parameter int ORDERS   = 7,
    parameter int SEGMENTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [3:0] segment,
    input  logic [5:0] page_index,
    input  logic [2:0] order,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [3:0] block_segment,
    output logic [5:0] block_page,
    output logic [2:0] block_order
);
    import bpa_pkg::*;

    dp_cmd_t    ctrl;
    dp_status_t stat;

    bpa_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bpa_datapath #(
        .ORDERS   (ORDERS),
        .SEGMENTS (SEGMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cmd           (cmd),
        .segment       (segment),
        .page_index    (page_index),
        .order         (order),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_segment (block_segment),
        .block_page    (block_page),
        .block_order   (block_order)
    );

endmodule

>>> hw/rtl/bpa_datapath.sv
// Datapath of the buddy page allocator: free bitmap memory with valid bits,
// per-order nonempty masks, command registers and the output register.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_datapath #(
    parameter int ORDERS   = 7,
    parameter int SEGMENTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpa_pkg::dp_cmd_t     ctrl,
    output bpa_pkg::dp_status_t  stat,
    input  logic [1:0]           cmd,
    input  logic [3:0]           segment,
    input  logic [5:0]           page_index,
    input  logic [2:0]           order,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [3:0]           block_segment,
    output logic [5:0]           block_page,
    output logic [2:0]           block_order
);
    import bpa_pkg::*;

    localparam int NSEG  = (SEGMENTS < 16) ? SEGMENTS : 16;
    localparam int DEPTH = ORDERS * NSEG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW    = $clog2(ORDERS);
    localparam int SW    = (NSEG > 1) ? $clog2(NSEG) : 1;

    logic [1:0]      cmd_reg;
    logic [2:0]      ord_reg;
    logic [2:0]      o_reg;
    logic [3:0]      s_reg;
    logic [5:0]      p_reg;
    logic [1:0]      st_reg;
    logic            zero_reg;
    logic            first_reg;
    logic [63:0]     rd_data_reg;
    logic            rd_vld_reg;
    logic [63:0]     mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [NSEG-1:0] ne_reg [ORDERS];
    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic [3:0]      bseg_reg;
    logic [5:0]      bpage_reg;
    logic [2:0]      bord_reg;

    logic [63:0]     cur;
    logic            bad;
    logic            misal;
    logic            found;
    logic [2:0]      fo;
    logic [3:0]      fs;
    logic [NSEG-1:0] sel;
    logic [5:0]      lowp;
    logic [5:0]      buddy;
    logic [5:0]      sp;
    logic            pbit;
    logic            bbit;
    logic            top_ok;
    logic            at_target;
    logic            hold;
    logic            merge;
    logic            wr_en;
    logic            rd_en;
    logic [63:0]     wd;
    logic [2:0]      ra_o;
    logic [3:0]      ra_s;
    logic [AW-1:0]   wa;
    logic [AW-1:0]   ra;

    function automatic logic [AW-1:0] addr_of(input logic [2:0] o, input logic [3:0] s);
        return AW'(int'(o) * NSEG + int'(s));
    endfunction

    assign cur       = rd_vld_reg ? rd_data_reg : 64'd0;
    assign bad       = int'(ord_reg) >= ORDERS;
    assign misal     = (int'(s_reg) >= SEGMENTS) || ((p_reg & ~(6'h3f << ord_reg)) != 6'd0);
    assign lowp      = lowest64(cur);
    assign buddy     = p_reg ^ (6'd1 << o_reg);
    assign sp        = p_reg + (6'd1 << o_reg);
    assign pbit      = cur[p_reg];
    assign bbit      = cur[buddy];
    assign top_ok    = (int'(o_reg) + 1) < ORDERS;
    assign at_target = o_reg == ord_reg;
    assign hold      = (cmd_reg != CMD_ADD) && first_reg && pbit;
    assign merge     = (cmd_reg != CMD_ADD) && !hold && top_ok && bbit;

    always_comb
    begin
        found = 1'b0;
        fo    = 3'd0;
        fs    = 4'd0;
        for (int i = ORDERS - 1; i >= 0; i--) begin
            if (i >= int'(ord_reg) && (|ne_reg[i])) begin
                found = 1'b1;
                fo    = 3'(i);
            end
        end
        sel = ne_reg[fo[OW-1:0]];
        for (int j = NSEG - 1; j >= 0; j--) begin
            if (sel[j]) begin
                fs = 4'(j);
            end
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        rd_en = 1'b0;
        wd    = cur;
        ra_o  = o_reg;
        ra_s  = s_reg;
        unique case (ctrl.op)
            OP_CHECK:
            begin
                if (!bad && cmd_reg == CMD_ALLOC && found) begin
                    rd_en = 1'b1;
                    ra_o  = fo;
                    ra_s  = fs;
                end else if (!bad && (cmd_reg == CMD_FREE || cmd_reg == CMD_ADD) && !misal) begin
                    rd_en = 1'b1;
                end
            end
            OP_PICK:
            begin
                wr_en = 1'b1;
                wd    = cur & ~(64'd1 << lowp);
                if (!at_target) begin
                    rd_en = 1'b1;
                    ra_o  = o_reg - 3'd1;
                end
            end
            OP_SPLIT:
            begin
                wr_en = 1'b1;
                wd    = cur | (64'd1 << sp);
                if (!at_target) begin
                    rd_en = 1'b1;
                    ra_o  = o_reg - 3'd1;
                end
            end
            OP_EVAL:
            begin
                if (merge) begin
                    wr_en = 1'b1;
                    wd    = cur & ~(64'd1 << buddy);
                    rd_en = 1'b1;
                    ra_o  = o_reg + 3'd1;
                end else if (!hold) begin
                    wr_en = 1'b1;
                    wd    = cur | (64'd1 << p_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign wa = addr_of(o_reg, s_reg);
    assign ra = addr_of(ra_o, ra_s);

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[ra];
            rd_vld_reg  <= vld_reg[ra];
        end
        unique case (ctrl.op)
            OP_LOAD:
            begin
                cmd_reg   <= cmd;
                ord_reg   <= order;
                o_reg     <= order;
                s_reg     <= segment;
                p_reg     <= page_index;
                first_reg <= 1'b1;
            end
            OP_CHECK:
            begin
                priority if (cmd_reg == CMD_NOP) begin
                    st_reg   <= ST_OK;
                    zero_reg <= 1'b1;
                end else if (bad) begin
                    st_reg   <= ST_BADORDER;
                    zero_reg <= 1'b1;
                end else if (cmd_reg == CMD_ALLOC) begin
                    if (found) begin
                        st_reg   <= ST_OK;
                        zero_reg <= 1'b0;
                        o_reg    <= fo;
                        s_reg    <= fs;
                    end else begin
                        st_reg   <= ST_NOMEM;
                        zero_reg <= 1'b1;
                    end
                end else if (misal) begin
                    st_reg   <= ST_MISALIGN;
                    zero_reg <= 1'b1;
                end else begin
                    st_reg   <= ST_OK;
                    zero_reg <= 1'b0;
                end
            end
            OP_PICK:
            begin
                p_reg <= lowp;
                if (!at_target) begin
                    o_reg <= o_reg - 3'd1;
                end
            end
            OP_SPLIT:
            begin
                if (!at_target) begin
                    o_reg <= o_reg - 3'd1;
                end
            end
            OP_EVAL:
            begin
                first_reg <= 1'b0;
                if (merge) begin
                    p_reg <= p_reg & ~(6'd1 << o_reg);
                    o_reg <= o_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (ctrl.out_load) begin
            status_reg <= st_reg;
            bseg_reg   <= zero_reg ? 4'd0 : s_reg;
            bpage_reg  <= zero_reg ? 6'd0 : p_reg;
            bord_reg   <= zero_reg ? 3'd0 : o_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ORDERS; i++) begin
                ne_reg[i] <= '0;
            end
        end else begin
            if (wr_en) begin
                vld_reg[wa] <= 1'b1;
                ne_reg[o_reg[OW-1:0]][s_reg[SW-1:0]] <= |wd;
            end
            if (ctrl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_alloc   = cmd_reg == CMD_ALLOC;
    assign stat.is_nop     = cmd_reg == CMD_NOP;
    assign stat.bad_order  = bad;
    assign stat.misalign   = misal;
    assign stat.found      = found;
    assign stat.at_target  = at_target;
    assign stat.eval_merge = merge;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_segment = bseg_reg;
    assign block_page    = bpage_reg;
    assign block_order   = bord_reg;

endmodule

>>> hw/rtl/bpa_controller.sv
// Controller state machine of the buddy page allocator.
// Sequences checks, allocation splits and free merges. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpa_pkg::dp_status_t stat,
    output bpa_pkg::dp_cmd_t    ctrl
);
    import bpa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        ctrl.op       = OP_NONE;
        ctrl.out_load = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctrl.op    = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl.op = OP_CHECK;
                priority if (stat.is_nop || stat.bad_order) begin
                    state_next = S_DONE;
                end else if (stat.is_alloc) begin
                    state_next = stat.found ? S_PICK : S_DONE;
                end else begin
                    state_next = stat.misalign ? S_DONE : S_EVAL;
                end
            end
            S_PICK:
            begin
                ctrl.op    = OP_PICK;
                state_next = stat.at_target ? S_DONE : S_SPLIT;
            end
            S_SPLIT:
            begin
                ctrl.op    = OP_SPLIT;
                state_next = stat.at_target ? S_DONE : S_SPLIT;
            end
            S_EVAL:
            begin
                ctrl.op    = OP_EVAL;
                state_next = stat.eval_merge ? S_EVAL : S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> bench/buddy_page_allocator_test.sv
// Self-checking bench for buddy_page_allocator: random and directed allocate,
// free, add and nop commands, checked against a bitmap model of the buddy pools.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 1ps

module buddy_page_allocator_test;
    import bpa_pkg::*;

    localparam int NORD = 7;
    localparam int NSEG = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] segment;
        logic [5:0] page;
        logic [2:0] order;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] segment;
        logic [5:0] page;
        logic [2:0] order;
    } block_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] cmd;
    logic [3:0] segment;
    logic [5:0] page_index;
    logic [2:0] order;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic [3:0] block_segment;
    logic [5:0] block_page;
    logic [2:0] block_order;

    request_t pending_requests[$];
    block_t expected_blocks[$];
    logic [63:0] pool_map[NORD][NSEG];
    int errors;
    int idle_cycles;
    int sent_count;
    int result_count;
    int send_gap;
    int recv_gap;
    int hold_off;
    bit stimulus_done;
    bit quiet_tail;

    buddy_page_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .segment(segment), .page_index(page_index), .order(order),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .block_segment(block_segment),
        .block_page(block_page), .block_order(block_order)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int first_set(input logic [63:0] v);
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic block_t allocate_model(input request_t r);
        block_t b;
        int o;
        int s;
        int p;
        b = '0;
        if (r.cmd == CMD_NOP)
        begin
            return b;
        end
        if (r.order >= NORD)
        begin
            b.status = ST_BADORDER;
            return b;
        end
        if (r.cmd == CMD_ALLOC)
        begin
            s = -1;
            o = r.order;
            while (o < NORD && s < 0)
            begin
                for (int k = 0; k < NSEG && s < 0; k++)
                begin
                    if (pool_map[o][k] != 0)
                    begin
                        s = k;
                    end
                end
                if (s < 0)
                begin
                    o++;
                end
            end
            if (s < 0)
            begin
                b.status = ST_NOMEM;
                return b;
            end
            p = first_set(pool_map[o][s]);
            pool_map[o][s][p] = 1'b0;
            while (o > r.order)
            begin
                o--;
                pool_map[o][s][p + (1 << o)] = 1'b1;
            end
            b.status = ST_OK;
            b.segment = 4'(s);
            b.page = 6'(p);
            b.order = r.order;
            return b;
        end
        if ((r.page & ((1 << r.order) - 1)) != 0)
        begin
            b.status = ST_MISALIGN;
            return b;
        end
        b.status = ST_OK;
        b.segment = r.segment;
        b.page = r.page;
        b.order = r.order;
        if (r.cmd == CMD_ADD)
        begin
            pool_map[r.order][r.segment][r.page] = 1'b1;
            return b;
        end
        if (pool_map[r.order][r.segment][r.page])
        begin
            return b;
        end
        o = r.order;
        p = r.page;
        while (o + 1 < NORD && pool_map[o][r.segment][p ^ (1 << o)])
        begin
            pool_map[o][r.segment][p ^ (1 << o)] = 1'b0;
            p = p & ~(1 << o);
            o++;
        end
        pool_map[o][r.segment][p] = 1'b1;
        b.page = 6'(p);
        b.order = 3'(o);
        return b;
    endfunction

    function automatic request_t make_request(input logic [1:0] c, input int s,
                                              input int p, input int o);
        request_t r;
        r.cmd = c;
        r.segment = 4'(s);
        r.page = 6'(p);
        r.order = 3'(o);
        return r;
    endfunction

    // Mostly aligned, in-range requests so blocks get split and merged deeply.
    function automatic request_t random_request();
        int o;
        int pick;
        request_t r;
        pick = $urandom_range(0, 99);
        o = $urandom_range(0, 6);
        r = make_request(CMD_ALLOC, $urandom_range(0, 15),
                         ($urandom_range(0, 63) >> o) << o, o);
        if (pick < 40)
        begin
            r.cmd = CMD_ALLOC;
        end
        else if (pick < 75)
        begin
            r.cmd = CMD_FREE;
        end
        else if (pick < 90)
        begin
            r.cmd = CMD_ADD;
        end
        else
        begin
            r.cmd = 2'($urandom_range(0, 3));
            r.segment = 4'($urandom_range(0, 15));
            r.page = 6'($urandom_range(0, 63));
            r.order = 3'($urandom_range(0, 7));
        end
        return r;
    endfunction

    initial
    begin
        for (int o = 0; o < NORD; o++)
        begin
            for (int s = 0; s < NSEG; s++)
            begin
                pool_map[o][s] = '0;
            end
        end
        errors = 0;
        stimulus_done = 1'b0;
        quiet_tail = 1'b0;
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_ALLOC, 15, 63, 7));
        pending_requests.push_back(make_request(CMD_ADD, 0, 0, 6));
        pending_requests.push_back(make_request(CMD_ADD, 15, 0, 6));
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 3));
        pending_requests.push_back(make_request(CMD_FREE, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_FREE, 0, 8, 3));
        pending_requests.push_back(make_request(CMD_FREE, 0, 8, 3));
        pending_requests.push_back(make_request(CMD_FREE, 0, 3, 1));
        pending_requests.push_back(make_request(CMD_ADD, 7, 63, 6));
        pending_requests.push_back(make_request(CMD_ADD, 15, 0, 6));
        pending_requests.push_back(make_request(CMD_ADD, 3, 62, 1));
        pending_requests.push_back(make_request(CMD_NOP, 15, 63, 7));
        pending_requests.push_back(make_request(CMD_FREE, 9, 32, 7));
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 6));
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 6));
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 6));
        pending_requests.push_back(make_request(CMD_FREE, 15, 0, 6));
        pending_requests.push_back(make_request(CMD_FREE, 0, 0, 6));
        for (int i = 0; i < 1400; i++)
        begin
            pending_requests.push_back(random_request());
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= '0;
            segment <= '0;
            page_index <= '0;
            order <= '0;
            send_gap <= 0;
            sent_count <= 0;
        end
        else
        begin
            automatic bit busy = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                expected_blocks.push_back(allocate_model({cmd, segment, page_index, order}));
                sent_count <= sent_count + 1;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    automatic request_t r = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    cmd <= r.cmd;
                    segment <= r.segment;
                    page_index <= r.page;
                    order <= r.order;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                    begin
                        send_gap <= $urandom_range(1, 15);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
            quiet_tail <= (pending_requests.size() < 150);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            hold_off <= 0;
            result_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t: unexpected result %h %h %h %h", $realtime, status,
                             block_segment, block_page, block_order);
                    errors++;
                end
                else
                begin
                    automatic block_t e = expected_blocks.pop_front();
                    if (e.status !== status || e.segment !== block_segment
                        || e.page !== block_page || e.order !== block_order)
                    begin
                        $display("%0t: expected st=%0d seg=%0d pg=%0d ord=%0d, got %0d %0d %0d %0d",
                                 $realtime, e.status, e.segment, e.page, e.order,
                                 status, block_segment, block_page, block_order);
                        errors++;
                    end
                end
            end
            if (sent_count == 300 && hold_off == 0)
            begin
                hold_off <= 200;
                out_ready <= 1'b0;
            end
            else if (hold_off > 1)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (hold_off == 1)
                begin
                    hold_off <= -1;
                end
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) == 0)
                begin
                    recv_gap <= $urandom_range(1, 15);
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (!(stimulus_done && expected_blocks.size() == 0) && idle_cycles < WATCHDOG)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Timed out with %0d results outstanding.", expected_blocks.size());
            $display("[FAIL] regression broken");
        end
        else
        begin
            repeat (20) @(posedge clk);
            $display("Ran %0d commands (directed edge cases, then random alloc/free/add).",
                     sent_count);
            $display("Checked %0d results, %0d mismatches.", result_count, errors);
            if (errors == 0)
            begin
                $display("[ OK ] regression clean");
            end
            else
            begin
                $display("[FAIL] regression broken");
            end
        end
        $finish;
    end

endmodule
